// ----- hw/rtl/brf_pkg.sv -----
// Shared types and constants for the chunked byte ring FIFO.
// No dependencies; imported by every module of the block.
`default_nettype none
package brf_pkg;

  // Ring depth must stay a power of two: pointers wrap by truncation.
  localparam int DEPTH     = 1024;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int MAX_CHUNK = 64;
  localparam int CNT_W     = 7;
  localparam int SIZE_W    = 10;

  typedef enum logic [2:0] {
    ACT_ENQ     = 3'd0,
    ACT_DEQ     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISCARD = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_QUERY   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NODATA  = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    act_t             action;
    logic [CNT_W-1:0] count;
    logic             start_of_chunk;
    logic [7:0]       data_byte;
  } in_word_t;

  typedef struct packed {
    stat_t             status;
    logic [7:0]        out_byte;
    logic              last;
    logic [CNT_W-1:0]  done_count;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] contiguous_write;
    logic [SIZE_W-1:0] contiguous_read;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // execute the word presented on the input
    logic step;   // emit one byte of a dequeue/peek chunk
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic launch;     // executed word starts a chunk read
    logic last_step;  // current step emits the final byte
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/brf_ctrl.sv -----
// Controller for the chunked byte ring FIFO: idle / chunk-read sequencer.
// Depends on brf_pkg.
`default_nettype none
module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.exec = start;
        if (start && sts.launch) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/brf_dp.sv -----
// Datapath for the chunked byte ring FIFO: byte store, pointers, chunk
// tracking and result register. Depends on brf_pkg.
`default_nettype none
module brf_dp
  import brf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dp_cmd_t  cmd,
  output dp_sts_t       sts,
  input  wire in_word_t in_word,
  output logic          out_strobe,
  output out_word_t     out_word
);

  logic [7:0] mem [DEPTH];

  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [CNT_W-1:0] crem_r, crem_nxt;
  logic             cdrop_r, cdrop_nxt;

  logic [PTR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [7:0]       rd_data_r;

  logic             valid_r, valid_nxt;
  stat_t            status_r, status_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic             is_byte_r, is_byte_nxt;

  logic             wr_en;
  logic [PTR_W-1:0] used, free_sz;
  logic [PTR_W:0]   cw, cr;
  logic [PTR_W:0]   cnt_ext;
  logic             cnt_big;

  // sizes from the current pointers
  always_comb begin
    used    = wptr_r - rptr_r;
    free_sz = PTR_W'(DEPTH - 1) - used;
    if (wptr_r >= rptr_r) begin
      cw = (PTR_W+1)'(DEPTH) - {1'b0, wptr_r} - {{PTR_W{1'b0}}, (rptr_r == '0)};
      cr = {1'b0, wptr_r - rptr_r};
    end else begin
      cw = {1'b0, rptr_r - wptr_r - PTR_W'(1)};
      cr = (PTR_W+1)'(DEPTH) - {1'b0, rptr_r};
    end
  end

  assign cnt_ext = (PTR_W+1)'(in_word.count);
  assign cnt_big = (in_word.count > CNT_W'(MAX_CHUNK));

  always_comb begin
    rptr_nxt    = rptr_r;
    wptr_nxt    = wptr_r;
    crem_nxt    = crem_r;
    cdrop_nxt   = cdrop_r;
    rd_addr_nxt = rd_addr_r;
    left_nxt    = left_r;
    valid_nxt   = 1'b0;
    status_nxt  = ST_OK;
    last_nxt    = 1'b1;
    done_nxt    = done_r;
    is_byte_nxt = 1'b0;
    wr_en       = 1'b0;
    sts         = '0;

    if (cmd.step) begin
      valid_nxt      = 1'b1;
      is_byte_nxt    = 1'b1;
      last_nxt       = (left_r == CNT_W'(1));
      sts.last_step  = (left_r == CNT_W'(1));
      rd_addr_nxt    = rd_addr_r + PTR_W'(1);
      left_nxt       = left_r - CNT_W'(1);
    end else if (cmd.exec) begin
      valid_nxt = 1'b1;
      done_nxt  = '0;
      unique case (in_word.action)
        ACT_ENQ: begin
          if (in_word.start_of_chunk) begin
            crem_nxt  = '0;
            cdrop_nxt = 1'b0;
            if (in_word.count != '0) begin
              crem_nxt = in_word.count - CNT_W'(1);
              if (cnt_big || cnt_ext > {1'b0, free_sz}) begin
                cdrop_nxt  = 1'b1;
                status_nxt = ST_NOSPACE;
              end else begin
                wr_en    = 1'b1;
                wptr_nxt = wptr_r + PTR_W'(1);
                done_nxt = CNT_W'(1);
              end
            end
          end else if (crem_r == '0) begin
            cdrop_nxt = 1'b0;
          end else begin
            crem_nxt = crem_r - CNT_W'(1);
            if (cdrop_r) begin
              if (crem_r == CNT_W'(1)) cdrop_nxt = 1'b0;
              status_nxt = ST_NOSPACE;
            end else begin
              wr_en    = 1'b1;
              wptr_nxt = wptr_r + PTR_W'(1);
              done_nxt = CNT_W'(1);
            end
          end
        end
        ACT_DEQ, ACT_PEEK: begin
          if (in_word.count != '0) begin
            if (cnt_big || cnt_ext > {1'b0, used}) begin
              status_nxt = ST_NODATA;
            end else begin
              // chunk read: results come from the step cycles
              valid_nxt   = 1'b0;
              sts.launch  = 1'b1;
              rd_addr_nxt = rptr_r;
              left_nxt    = in_word.count;
              done_nxt    = in_word.count;
              if (in_word.action == ACT_DEQ) begin
                rptr_nxt = rptr_r + PTR_W'(in_word.count);
              end
            end
          end
        end
        ACT_DISCARD: begin
          if (cnt_ext > {1'b0, used}) begin
            status_nxt = ST_NODATA;
          end else begin
            rptr_nxt = rptr_r + PTR_W'(in_word.count);
            done_nxt = in_word.count;
          end
        end
        ACT_CLEAR: begin
          rptr_nxt  = '0;
          wptr_nxt  = '0;
          crem_nxt  = '0;
          cdrop_nxt = 1'b0;
        end
        default: begin
          // query and unused codes: report only
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= in_word.data_byte;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r  <= '0;
      wptr_r  <= '0;
      crem_r  <= '0;
      cdrop_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      crem_r  <= crem_nxt;
      cdrop_r <= cdrop_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    left_r    <= left_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
    done_r    <= done_nxt;
    is_byte_r <= is_byte_nxt;
  end

  // pointers only move on the cycle a word executes, so the sizes seen
  // while a result is shown are the sizes after that word
  assign out_strobe                = valid_r;
  assign out_word.status           = status_r;
  assign out_word.out_byte         = is_byte_r ? rd_data_r : 8'h00;
  assign out_word.last             = last_r;
  assign out_word.done_count       = done_r;
  assign out_word.used_bytes       = SIZE_W'(used);
  assign out_word.free_bytes       = SIZE_W'(free_sz);
  assign out_word.contiguous_write = SIZE_W'(cw);
  assign out_word.contiguous_read  = SIZE_W'(cr);

endmodule
`default_nettype wire

// ----- hw/rtl/byte_ring_fifo_chunked.sv -----
// Chunked byte ring FIFO: 1024 x 8 ring with one slot kept empty.
// Results: a single-result word shows its result in the cycle after it is accepted;
//   a dequeue/peek chunk's first byte passes the read address and read data registers.
// Enqueue, discard, clear and query never raise busy; dequeue and peek of N > 0 bytes
//   hold busy after the launch while the bytes stream out, one byte per cycle from
//   the store's single registered read port. The receiver never stalls.
// Reset (rst_n, synchronous): pointers and chunk tracking clear; store keeps data.
`default_nettype none
module byte_ring_fifo_chunked
  import brf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // command channel: word taken when start && !busy
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  // result channel: one word per out_strobe cycle, no back-pressure
  output logic          out_strobe,
  output out_word_t     out_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: idle while single-result words execute; holds busy while a
  // dequeue/peek chunk streams out.
  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Store, pointers, chunk admission and result register.
  brf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire
